/* design/cttr_pkg.sv */
`timescale 1ns / 1ps

package cttr_pkg;

  // Number of connection table entries.
  localparam int ENTRIES = 128;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [7:0] FLAG_MASK   = 8'h17;
  localparam logic [7:0] FLAG_SYN    = 8'h02;
  localparam logic [7:0] FLAG_ACK    = 8'h10;
  localparam logic [7:0] FLAG_FINACK = 8'h11;

  localparam logic [3:0] PH_CLOSED    = 4'd0;
  localparam logic [3:0] PH_LISTEN    = 4'd1;
  localparam logic [3:0] PH_SYNRCVD   = 4'd3;
  localparam logic [3:0] PH_ESTAB     = 4'd4;
  localparam logic [3:0] PH_CLOSEWAIT = 4'd7;

  localparam logic [31:0] SEQ_STEP = 32'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [31:0] laddr;
    logic [31:0] raddr;
    logic [15:0] lport;
    logic [15:0] rport;
  } tuple_t;

  typedef struct packed {
    tuple_t      tuple;
    logic [3:0]  phase;
    logic [31:0] own_seq;
  } entry_t;

  localparam int ROW_W = $bits(entry_t);

  typedef struct packed {
    logic clear;
    logic sample;
    idx_t idx;
  } scan_ctl_t;

  typedef struct packed {
    logic        match_found;
    idx_t        match_idx;
    logic [3:0]  match_phase;
    logic [31:0] match_seq;
    logic        free_found;
    idx_t        free_idx;
    entry_t      free_row;
  } scan_res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

/* design/cttr_ram.sv */
`timescale 1ns / 1ps

module cttr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/cttr_scan.sv */
`timescale 1ns / 1ps

module cttr_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  cttr_pkg::scan_ctl_t ctl,
  input  cttr_pkg::tuple_t    key,
  input  cttr_pkg::entry_t    row,
  output cttr_pkg::scan_res_t res
);
  import cttr_pkg::*;

  logic      is_open;
  logic      is_hit;
  scan_res_t res_r;

  // An entry matches only while open; the first closed entry is the free one.
  assign is_open = (row.phase != PH_CLOSED);
  assign is_hit  = is_open && (row.tuple == key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.match_found <= 1'b0;
      res_r.free_found  <= 1'b0;
    end else if (ctl.clear) begin
      res_r.match_found <= 1'b0;
      res_r.free_found  <= 1'b0;
    end else if (ctl.sample) begin
      if (!res_r.match_found && is_hit) begin
        res_r.match_found <= 1'b1;
        res_r.match_idx   <= ctl.idx;
        res_r.match_phase <= row.phase;
        res_r.match_seq   <= row.own_seq;
      end
      if (!res_r.free_found && !is_open) begin
        res_r.free_found <= 1'b1;
        res_r.free_idx   <= ctl.idx;
        res_r.free_row   <= row;
      end
    end
  end

  assign res = res_r;

endmodule

/* design/tcp_connection_tracker_core.sv */
`timescale 1ns / 1ps

// Receive-side TCP connection table.
// A segment (4-tuple, flag byte and sequence number) is transferred in at a
// rising edge where start is high and busy is low. The core then reads every
// table entry once, one per cycle through the single read port of the table
// memory, noting the first open entry with a matching tuple and the first
// closed entry. The ST_DONE state then writes the updated entry back.
// Each segment yields exactly one result, shown for one cycle with out_valid
// high; it is registered from the ST_DONE state. busy is low again in the
// cycle the result is shown, so a new segment may be transferred at the
// edge that ends it; no new segment is taken while the walk over the table
// memory and its write-back are under way.
// After reset the core clears the table, one entry per cycle, with busy
// high; the sequence counter starts at zero.
// The receiver cannot stall the result: it must take each transfer in the
// cycle out_valid is high.
module tcp_connection_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_local_addr,
  input  logic [31:0] in_remote_addr,
  input  logic [15:0] in_local_port_in,
  input  logic [15:0] in_remote_port_in,
  input  logic [7:0]  in_tcp_flags,
  input  logic [31:0] in_peer_seq,
  output logic        out_valid,
  output logic        out_status,
  output logic [6:0]  out_entry_index,
  output logic [3:0]  out_entry_state,
  output logic        out_send_synack,
  output logic [31:0] out_reply_seq,
  output logic [31:0] out_reply_ack
);
  import cttr_pkg::*;

  state_t      state_r, state_nxt;
  cnt_t        cnt_r, cnt_nxt;
  logic        rd_vld_r;
  idx_t        rd_idx_r;
  tuple_t      key_r;
  logic [7:0]  flags_r;
  logic [31:0] pseq_r;
  logic [31:0] seq_ctr_r;

  logic        ram_we;
  idx_t        ram_waddr;
  entry_t      ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  entry_t      rd_row;

  scan_ctl_t   scan_ctl;
  scan_res_t   scan_res;

  logic        found;
  logic        is_syn;
  idx_t        hit_idx;
  entry_t      base_row;
  entry_t      new_row;
  logic [7:0]  flags_m;

  logic        out_valid_r;
  logic        out_status_r;
  logic [6:0]  out_index_r;
  logic [3:0]  out_state_r;
  logic        out_synack_r;
  logic [31:0] out_seq_r;
  logic [31:0] out_ack_r;

  // The whole table lives in one memory, one row per entry.
  cttr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_row = entry_t'(ram_rdata);

  // Read data is registered in the memory, so the sample strobe and
  // entry number are the ones registered alongside the read.
  assign scan_ctl.clear  = (state_r == ST_IDLE) && start;
  assign scan_ctl.sample = rd_vld_r;
  assign scan_ctl.idx    = rd_idx_r;

  cttr_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .key   (key_r),
    .row   (rd_row),
    .res   (scan_res)
  );

  // Update of the chosen entry. The base row is a matched entry with its tuple
  // (which equals the key) and phase, or a claimed free entry with its old tuple
  // and phase listen; SYN, ACK and FIN-ACK then set the phase, SYN also the key.
  assign found   = scan_res.match_found || scan_res.free_found;
  assign hit_idx = scan_res.match_found ? scan_res.match_idx : scan_res.free_idx;
  assign flags_m = flags_r & FLAG_MASK;
  assign is_syn  = (flags_m == FLAG_SYN);

  always_comb begin
    if (scan_res.match_found) begin
      base_row.tuple   = key_r;
      base_row.phase   = scan_res.match_phase;
      base_row.own_seq = scan_res.match_seq;
    end else begin
      base_row       = scan_res.free_row;
      base_row.phase = PH_LISTEN;
    end
    new_row = base_row;
    case (flags_m)
      FLAG_SYN: begin
        new_row.tuple   = key_r;
        new_row.phase   = PH_SYNRCVD;
        new_row.own_seq = seq_ctr_r;
      end
      FLAG_ACK:    new_row.phase = PH_ESTAB;
      FLAG_FINACK: new_row.phase = PH_CLOSEWAIT;
      default:     new_row = base_row;
    endcase
  end

  // Sequencer. The table is never read while a write is pending: the write
  // of one segment happens in the final cycle, before the next walk starts.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[IDX_W-1:0];
    ram_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_r != CNT_W'(ENTRIES)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ram_we    = found;
        ram_waddr = hit_idx;
        ram_wdata = new_row;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      seq_ctr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= (state_r == ST_SCAN) && (cnt_r != CNT_W'(ENTRIES));
      out_valid_r <= (state_r == ST_DONE);
      if ((state_r == ST_DONE) && found && is_syn) begin
        seq_ctr_r <= seq_ctr_r + SEQ_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[IDX_W-1:0];
    if ((state_r == ST_IDLE) && start) begin
      key_r.laddr <= in_local_addr;
      key_r.raddr <= in_remote_addr;
      key_r.lport <= in_local_port_in;
      key_r.rport <= in_remote_port_in;
      flags_r     <= in_tcp_flags;
      pseq_r      <= in_peer_seq;
    end
    if (state_r == ST_DONE) begin
      out_status_r <= !found;
      out_index_r  <= found ? 7'(hit_idx) : 7'd0;
      out_state_r  <= found ? new_row.phase : PH_CLOSED;
      out_synack_r <= found && is_syn;
      out_seq_r    <= (found && is_syn) ? seq_ctr_r : 32'd0;
      out_ack_r    <= (found && is_syn) ? (pseq_r + 32'd1) : 32'd0;
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_index_r;
  assign out_entry_state = out_state_r;
  assign out_send_synack = out_synack_r;
  assign out_reply_seq   = out_seq_r;
  assign out_reply_ack   = out_ack_r;

  // A result only ever follows the write-back cycle.
  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DONE))
    else $error("result shown without an update cycle");

  // An accepted segment keeps the core busy for the walk over the table.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("core not busy after taking a segment");

  // A SYN-ACK request always leaves its entry in syn-received.
  a_synack_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_synack) |-> (out_entry_state == PH_SYNRCVD && !out_status))
    else $error("SYN-ACK with wrong entry phase");

  // A full table reports nothing but the error.
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (out_entry_index == 7'd0 && !out_send_synack && out_reply_seq == 32'd0))
    else $error("error result carries entry data");

endmodule
